// ===== rtl/rep_pkg.sv =====
// Shared constants for the rotated ellipse pixel cover block.
// Holds register indexes, fixed field widths and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package rep_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SEMI_BITS      = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int COLOR_BITS     = 16;

  localparam logic [COLOR_BITS-1:0] COLOR_WHITE = 16'hFFFF;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEMI     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRETCH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COS      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIN      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_W = 3'd6;

  localparam int RST_CENTER_X = 110;
  localparam int RST_CENTER_Y = 120;
  localparam int RST_SEMI     = 2621440;
  localparam int RST_SCREEN_W = 320;

endpackage

// ===== rtl/rotated_ellipse_pixel_cover_core.sv =====
// Top level of the rotated ellipse pixel cover block.
// Uses rep_pkg constants and a chain of rep_div_cell instances per axis.
`timescale 1ns / 1ps

// Takes one pixel per cycle and returns one covered flag and color per pixel,
// in order, through stages A to D, two chains of FRAC_BITS + 1 division cells,
// one quotient bit per cell, that divide the rotated offsets by the two
// semi-axes, stage E and the output register. The whole pipeline holds
// while a result waits on a low out_ready_i side; otherwise a new request is
// taken every cycle. Write the registers only while no request is in flight.

module rotated_ellipse_pixel_cover_core #(
  parameter int COORD_BITS = rep_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rep_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rep_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [rep_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [COORD_BITS-1:0]                pixel_x_i,
  input  logic [COORD_BITS-1:0]                pixel_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 covered_o,
  output logic [rep_pkg::COLOR_BITS-1:0]       color_o
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int S   = rep_pkg::SEMI_BITS;
  localparam int T   = F + 2;
  localparam int P   = C + 1 + T;
  localparam int M   = P + 1;
  localparam int NW  = M + F;
  localparam int DW  = S + 2;
  localparam int RW  = ((NW > DW + F + 1) ? NW : (DW + F + 1)) + 1;
  localparam int QW  = F + 1;
  localparam int BXB = S - F + 1;
  localparam int BXW = ((C > BXB) ? C : BXB) + 1;
  localparam int NC  = F + 1;

  // configuration
  logic [C-1:0]   cx_q, cy_q;
  logic [S-1:0]   semi_q;
  logic [F:0]     str_q;
  logic [T-1:0]   cos_q, sin_q;
  logic [C:0]     sw_q;
  logic [DW-1:0]  b_q;
  logic [S+F:0]   as_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= C'(rep_pkg::RST_CENTER_X);
      cy_q   <= C'(rep_pkg::RST_CENTER_Y);
      semi_q <= S'(rep_pkg::RST_SEMI);
      str_q  <= (F+1)'(1) << (F - 2);
      cos_q  <= T'(1) << F;
      sin_q  <= '0;
      sw_q   <= (C+1)'(rep_pkg::RST_SCREEN_W);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rep_pkg::CFG_CENTER_X: cx_q   <= cfg_data_i[C-1:0];
        rep_pkg::CFG_CENTER_Y: cy_q   <= cfg_data_i[C-1:0];
        rep_pkg::CFG_SEMI:     semi_q <= cfg_data_i[S-1:0];
        rep_pkg::CFG_STRETCH:  str_q  <= cfg_data_i[F:0];
        rep_pkg::CFG_COS:      cos_q  <= cfg_data_i[T-1:0];
        rep_pkg::CFG_SIN:      sin_q  <= cfg_data_i[T-1:0];
        rep_pkg::CFG_SCREEN_W: sw_q   <= cfg_data_i[C:0];
        default: ;
      endcase
    end
  end

  assign as_w = (S+F+1)'(semi_q) * (S+F+1)'(str_q);

  always_ff @(posedge clk_i) begin
    b_q <= DW'(semi_q) + DW'(as_w[S+F:F]);
  end

  // pipeline control
  logic en_w;
  logic va_q, vb_q, vc_q, vd_q, ve_q, vo_q;
  logic [NC:1] vcell_q;

  assign en_w       = !(vo_q && !out_ready_i);
  assign in_ready_o = en_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      vcell_q <= '0;
      ve_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else if (en_w) begin
      va_q    <= in_valid_i;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      vcell_q <= {vcell_q[NC-1:1], vd_q};
      ve_q    <= vcell_q[NC];
      vo_q    <= ve_q;
    end
  end

  // stage A: box test and offsets
  logic [BXW-1:0] box_w, px_w, cx_w;
  logic           box_ok_w;
  logic signed [C:0] ddx_q, ddy_q;
  logic           boxa_q;

  assign box_w    = BXW'(semi_q[S-1:F]) + BXW'(1);
  assign px_w     = BXW'(pixel_x_i);
  assign cx_w     = BXW'(cx_q);
  assign box_ok_w = (semi_q != '0) && (px_w + box_w >= cx_w) &&
                    (px_w <= cx_w + box_w) && ((C+1)'(pixel_x_i) < sw_q);

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      ddx_q  <= $signed({1'b0, pixel_x_i}) - $signed({1'b0, cx_q});
      ddy_q  <= $signed({1'b0, pixel_y_i}) - $signed({1'b0, cy_q});
      boxa_q <= box_ok_w;
    end
  end

  // stage B: products
  logic signed [P-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic                boxb_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      pxc_q  <= P'(ddx_q) * P'($signed(cos_q));
      pys_q  <= P'(ddy_q) * P'($signed(sin_q));
      pxs_q  <= P'(ddx_q) * P'($signed(sin_q));
      pyc_q  <= P'(ddy_q) * P'($signed(cos_q));
      boxb_q <= boxa_q;
    end
  end

  // stage C: rotated magnitudes
  logic signed [P:0] rx_w, ry_w;
  logic [M-1:0]      mx_q, my_q;
  logic              boxc_q;

  assign rx_w = (P+1)'(pxc_q) - (P+1)'(pys_q);
  assign ry_w = (P+1)'(pxs_q) + (P+1)'(pyc_q);

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      mx_q   <= rx_w[P] ? M'(-rx_w) : M'(rx_w);
      my_q   <= ry_w[P] ? M'(-ry_w) : M'(ry_w);
      boxc_q <= boxb_q;
    end
  end

  // stage D: dividends and top overflow check
  logic [RW-1:0] nx_w, ny_w;
  logic [DW-1:0] dx_w;
  logic [RW-1:0] rem_x [NC+1];
  logic [RW-1:0] rem_y [NC+1];
  logic [DW-1:0] den_x [NC+1];
  logic [DW-1:0] den_y [NC+1];
  logic [QW-1:0] quo_x [NC+1];
  logic [QW-1:0] quo_y [NC+1];
  logic          big_x [NC+1];
  logic          big_y [NC+1];
  logic [NC:0]   boxp_q;

  assign nx_w = RW'(mx_q) << F;
  assign ny_w = RW'(my_q) << F;
  assign dx_w = DW'(semi_q);

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      rem_x[0]  <= nx_w;
      rem_y[0]  <= ny_w;
      den_x[0]  <= dx_w;
      den_y[0]  <= b_q;
      quo_x[0]  <= '0;
      quo_y[0]  <= '0;
      big_x[0]  <= (nx_w >= (RW'(dx_w) << (F + 1)));
      big_y[0]  <= (ny_w >= (RW'(b_q) << (F + 1)));
      boxp_q    <= {boxp_q[NC-1:0], boxc_q};
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rep_div_cell #(.RW(RW), .DW(DW), .QW(QW), .BIT(F - k)) u_cx (
      .clk_i (clk_i),
      .en_i  (en_w),
      .rem_i (rem_x[k]),
      .den_i (den_x[k]),
      .quo_i (quo_x[k]),
      .big_i (big_x[k]),
      .rem_o (rem_x[k+1]),
      .den_o (den_x[k+1]),
      .quo_o (quo_x[k+1]),
      .big_o (big_x[k+1])
    );
    rep_div_cell #(.RW(RW), .DW(DW), .QW(QW), .BIT(F - k)) u_cy (
      .clk_i (clk_i),
      .en_i  (en_w),
      .rem_i (rem_y[k]),
      .den_i (den_y[k]),
      .quo_i (quo_y[k]),
      .big_i (big_y[k]),
      .rem_o (rem_y[k+1]),
      .den_o (den_y[k+1]),
      .quo_o (quo_y[k+1]),
      .big_o (big_y[k+1])
    );
  end

  // stage E: squares
  logic [2*QW-1:0] sqx_q, sqy_q;
  logic            oke_q;
  logic [QW-1:0]   one_w;

  assign one_w = QW'(1) << F;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      sqx_q <= (2*QW)'(quo_x[NC]) * (2*QW)'(quo_x[NC]);
      sqy_q <= (2*QW)'(quo_y[NC]) * (2*QW)'(quo_y[NC]);
      oke_q <= boxp_q[NC] && !big_x[NC] && !big_y[NC] &&
               (quo_x[NC] <= one_w) && (quo_y[NC] <= one_w);
    end
  end

  // output register
  logic [2*QW:0] sum_w;
  logic          cov_q;

  assign sum_w = (2*QW+1)'(sqx_q) + (2*QW+1)'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      cov_q <= oke_q && (sum_w <= ((2*QW+1)'(1) << (2 * F)));
    end
  end

  assign out_valid_o = vo_q;
  assign covered_o   = cov_q;
  assign color_o     = cov_q ? rep_pkg::COLOR_WHITE : '0;

endmodule

// ===== rtl/rep_div_cell.sv =====
// One restoring-division cell: decides one quotient bit and hands the
// partial remainder, divisor, quotient and overflow flag to the next cell.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rep_div_cell #(
  parameter int RW  = 49,
  parameter int DW  = 26,
  parameter int QW  = 17,
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic          big_i,
  output logic [RW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic          big_o
);

  logic [RW-1:0] sub_w;
  logic          take_w;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic [RW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;
  logic          big_q;

  assign sub_w  = RW'(den_i) << BIT;
  assign take_w = (rem_i >= sub_w);
  assign rem_d  = take_w ? (rem_i - sub_w) : rem_i;
  assign quo_d  = quo_i | (QW'(take_w) << BIT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
      big_q <= big_i;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
  assign big_o = big_q;

endmodule
